// ===== rtl/shct_pkg.sv =====
// ----------------------------------------------------------------------------
// shct_pkg: shared hit count table definitions
// Command codes, sequencer states, entry layout and numeric limits shared by
// the memory, the controller and the top level.
// ----------------------------------------------------------------------------
package shct_pkg;

  // Default table depth
  localparam int DEF_TABLE_ENTRIES = 256;

  // Limits of stored values
  localparam logic [7:0]         COUNT_MAX  = 8'd255;
  localparam logic signed [23:0] ENERGY_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] ENERGY_MIN = 24'sh800000;
  localparam int                 TALLY_MAX  = 511;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS
  } state_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [11:0]        chain;
    logic [9:0]         hit;
    logic [7:0]         count;
    logic signed [23:0] energy;
  } entry_t;

endpackage

// ===== rtl/shared_hit_count_table.sv =====
// ----------------------------------------------------------------------------
// shared_hit_count_table: table of hits with share counts and energies
// Keyed by (chain, hit index); insert, take, lookup and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (command, key_chain, key_hit, energy_in) is taken at a
//   rising edge with start high and busy low. Each command produces exactly
//   one result beat, shown for one cycle with done high; the receiver cannot
//   stall it, so it must take the beat in that cycle.
//   Clear takes effect at once: done is high in the cycle right after the
//   beat and busy stays low.
//   Insert, take and lookup scan the used entries in order, one entry per
//   cycle through a single key comparator fed by the entry memory read port.
//   A key match moves the sequencer to ST_HIT; when no entry is left to compare
//   it moves to ST_MISS. Either state loads the result, and done rises from
//   the registered result strobe.
//   busy falls in the cycle done rises, so the next beat may be taken then.
//   Reset empties the table (occupancy and tally counters cleared); the entry
//   memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module shared_hit_count_table #(
  parameter int TABLE_ENTRIES = shct_pkg::DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [11:0]        key_chain,
  input  logic [9:0]         key_hit,
  input  logic signed [23:0] energy_in,
  output logic               done,
  output logic               found,
  output logic [7:0]         share_count,
  output logic signed [23:0] energy_out,
  output logic [8:0]         multi_shared_total,
  output logic               table_full
);
  import shct_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic          wen;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic          ren;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  // Sequencer with the shared key comparator
  shct_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IW            (IW),
    .CW            (CW)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .command            (command),
    .key_chain          (key_chain),
    .key_hit            (key_hit),
    .energy_in          (energy_in),
    .done               (done),
    .found              (found),
    .share_count        (share_count),
    .energy_out         (energy_out),
    .multi_shared_total (multi_shared_total),
    .table_full         (table_full),
    .wen                (wen),
    .waddr              (waddr),
    .wdata              (wdata),
    .ren                (ren),
    .raddr              (raddr),
    .rdata              (rdata)
  );

  // Entry storage
  shct_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IW            (IW)
  ) u_mem (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A searching command keeps the block busy in the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command != CMD_CLEAR) |=> busy)
    else $error("search command did not raise busy");

  // No result beat without a command beat or a finishing search
  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result beat without a command");

  // A dropped insert reports an absent key
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> !found && (share_count == 8'd0) && (energy_out == 24'sd0))
    else $error("dropped insert reported entry data");

  // Memory is never written while a search read is under way
  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(wen && ren))
    else $error("entry memory read and written together");

endmodule

// ===== rtl/shct_mem.sv =====
// ----------------------------------------------------------------------------
// shct_mem: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shct_mem #(
  parameter int TABLE_ENTRIES = 256,
  parameter int IW            = 8
) (
  input  logic            clk,
  input  logic            wen,
  input  logic [IW-1:0]   waddr,
  input  shct_pkg::entry_t wdata,
  input  logic            ren,
  input  logic [IW-1:0]   raddr,
  output shct_pkg::entry_t rdata
);
  import shct_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/shct_ctrl.sv =====
// ----------------------------------------------------------------------------
// shct_ctrl: search and update sequencer
// Scans used entries one per cycle through a single key comparator, then
// applies the command to a match, or appends on an insert miss with room.
// ----------------------------------------------------------------------------
module shct_ctrl #(
  parameter int TABLE_ENTRIES = 256,
  parameter int IW            = 8,
  parameter int CW            = 9
) (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic [11:0]         key_chain,
  input  logic [9:0]          key_hit,
  input  logic signed [23:0]  energy_in,
  // result side
  output logic                done,
  output logic                found,
  output logic [7:0]          share_count,
  output logic signed [23:0]  energy_out,
  output logic [8:0]          multi_shared_total,
  output logic                table_full,
  // memory side
  output logic                wen,
  output logic [IW-1:0]       waddr,
  output shct_pkg::entry_t    wdata,
  output logic                ren,
  output logic [IW-1:0]       raddr,
  input  shct_pkg::entry_t    rdata
);
  import shct_pkg::*;

  state_t             state, state_next;
  cmd_t               cmd_q;
  logic [11:0]        chain_q;
  logic [9:0]         hit_q;
  logic signed [23:0] energy_q;
  logic [CW-1:0]      used, used_next;
  logic [CW-1:0]      tally, tally_next;
  logic [CW-1:0]      rd_idx;
  logic [IW-1:0]      cmp_idx;
  logic               cmp_vld;
  logic               accept;
  logic               key_match;
  logic               scan_more;
  logic               res_load;
  logic               res_found;
  logic [7:0]         res_count;
  logic signed [23:0] res_energy;
  logic               res_full;
  logic signed [24:0] diff;
  logic signed [23:0] diff_sat;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign key_match = cmp_vld && (rdata.chain == chain_q) && (rdata.hit == hit_q);
  assign scan_more = (rd_idx < used);
  assign raddr     = rd_idx[IW-1:0];

  // Saturating energy subtraction for take
  assign diff = {rdata.energy[23], rdata.energy} - {energy_q[23], energy_q};
  always_comb begin
    if (diff[24] != diff[23]) begin
      diff_sat = diff[24] ? ENERGY_MIN : ENERGY_MAX;
    end else begin
      diff_sat = diff[23:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory strobes and result values
  always_comb begin
    state_next = state;
    ren        = 1'b0;
    wen        = 1'b0;
    waddr      = cmp_idx;
    wdata      = rdata;
    used_next  = used;
    tally_next = tally;
    res_load   = 1'b0;
    res_found  = 1'b0;
    res_count  = 8'd0;
    res_energy = 24'sd0;
    res_full   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(command) == CMD_CLEAR) begin
            used_next  = '0;
            tally_next = '0;
            res_load   = 1'b1;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (key_match) begin
          state_next = ST_HIT;
        end else if (scan_more) begin
          ren = 1'b1;
        end else if (!cmp_vld) begin
          state_next = ST_MISS;
        end
      end
      ST_HIT: begin
        state_next = ST_IDLE;
        res_load   = 1'b1;
        res_found  = 1'b1;
        case (cmd_q)
          CMD_INSERT: begin
            if (rdata.count != COUNT_MAX) begin
              wdata.count = rdata.count + 8'd1;
              if (rdata.count == 8'd1) begin
                tally_next = tally + CW'(1);
              end
            end
            wen = 1'b1;
          end
          CMD_TAKE: begin
            if (rdata.count != 8'd0) begin
              wdata.count = rdata.count - 8'd1;
              if (rdata.count == 8'd2) begin
                tally_next = tally - CW'(1);
              end
            end
            wdata.energy = diff_sat;
            wen = 1'b1;
          end
          default: begin
          end
        endcase
        res_count  = wdata.count;
        res_energy = wdata.energy;
      end
      ST_MISS: begin
        state_next = ST_IDLE;
        res_load   = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          if (used < CW'(TABLE_ENTRIES)) begin
            wen          = 1'b1;
            waddr        = used[IW-1:0];
            wdata.chain  = chain_q;
            wdata.hit    = hit_q;
            wdata.count  = 8'd1;
            wdata.energy = energy_q;
            used_next    = used + CW'(1);
            res_count    = 8'd1;
            res_energy   = energy_q;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd_t'(command);
      chain_q  <= key_chain;
      hit_q    <= key_hit;
      energy_q <= energy_in;
    end
  end

  // Table occupancy and shared tally
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      tally <= '0;
    end else begin
      used  <= used_next;
      tally <= tally_next;
    end
  end

  // Advance the scan pointer; the compare runs in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= ren;
      if (accept) begin
        rd_idx <= '0;
      end else if (ren) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      cmp_idx <= rd_idx[IW-1:0];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_load;
    end
  end

  // Result payload, tally clipped to the port width
  always_ff @(posedge clk) begin
    if (res_load) begin
      found       <= res_found;
      share_count <= res_count;
      energy_out  <= res_energy;
      table_full  <= res_full;
      if (32'(tally_next) > TALLY_MAX) begin
        multi_shared_total <= 9'(TALLY_MAX);
      end else begin
        multi_shared_total <= 9'(tally_next);
      end
    end
  end

endmodule
